>>> hdl/cpsb_pkg.sv
package cpsb_pkg;

  // Screen geometry
  localparam int SCREEN_WIDTH  = 320;
  localparam int SCREEN_HEIGHT = 200;
  localparam int X_BITS        = $clog2(SCREEN_WIDTH);
  localparam int Y_BITS        = $clog2(SCREEN_HEIGHT);

  // Field widths
  localparam int BYTE_W   = 8;
  localparam int COL_W    = 12;
  localparam int SPW_W    = 13;
  localparam int ORG_W    = 16;
  localparam int BASE_W   = 24;
  localparam int ADDR_W   = 25;
  // top row plus row within post, at most 254 + 254
  localparam int ROWSUM_W = 9;
  // signed screen coordinate: origin - offset + column or row
  localparam int COORD_W  = 19;
  localparam int DCOL_W   = 15;

  // Post data markers
  localparam logic [BYTE_W-1:0] END_MARK = 8'hff;

  // Register map (index = paddr / 4)
  localparam int REG_IDX_W = 3;
  localparam int PADDR_W   = 5;
  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_X    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Y    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_LEFT_OFFSET = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_TOP_OFFSET  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SPRITE_W    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_MIRROR      = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_BASE  = 3'd6;

  // Configuration seen by the datapath
  typedef struct packed {
    logic signed [ORG_W-1:0] origin_x;
    logic signed [ORG_W-1:0] origin_y;
    logic signed [ORG_W-1:0] left_offset;
    logic signed [ORG_W-1:0] top_offset;
    logic        [SPW_W-1:0] sprite_width;
    logic                    mirror;
    logic       [BASE_W-1:0] frame_base;
  } cpsb_cfg_t;

  // One parsed pixel handed from the parser to the address stage
  typedef struct packed {
    logic   [COL_W-1:0]    column;
    logic   [ROWSUM_W-1:0] rowsum;
    logic   [BYTE_W-1:0]   pixel;
    logic                  post_end;
  } cpsb_pix_t;

endpackage

>>> hdl/cpsb_cfg_regs.sv
module cpsb_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cpsb_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output cpsb_pkg::cpsb_cfg_t         cfg
);
  import cpsb_pkg::*;

  cpsb_cfg_t                cfg_r;
  logic                     wr_en;
  logic [REG_IDX_W-1:0]     idx;

  assign idx    = paddr[PADDR_W-1:2];
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign cfg    = cfg_r;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x     <= '0;
      cfg_r.origin_y     <= '0;
      cfg_r.left_offset  <= '0;
      cfg_r.top_offset   <= '0;
      cfg_r.sprite_width <= SPW_W'(1);
      cfg_r.mirror       <= 1'b0;
      cfg_r.frame_base   <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_ORIGIN_X:    cfg_r.origin_x     <= pwdata[ORG_W-1:0];
        REG_ORIGIN_Y:    cfg_r.origin_y     <= pwdata[ORG_W-1:0];
        REG_LEFT_OFFSET: cfg_r.left_offset  <= pwdata[ORG_W-1:0];
        REG_TOP_OFFSET:  cfg_r.top_offset   <= pwdata[ORG_W-1:0];
        REG_SPRITE_W:    cfg_r.sprite_width <= pwdata[SPW_W-1:0];
        REG_MIRROR:      cfg_r.mirror       <= pwdata[0];
        REG_FRAME_BASE:  cfg_r.frame_base   <= pwdata[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  // Readback, raw register bits zero-extended
  always_comb begin
    unique case (idx)
      REG_ORIGIN_X:    prdata = 32'({cfg_r.origin_x});
      REG_ORIGIN_Y:    prdata = 32'({cfg_r.origin_y});
      REG_LEFT_OFFSET: prdata = 32'({cfg_r.left_offset});
      REG_TOP_OFFSET:  prdata = 32'({cfg_r.top_offset});
      REG_SPRITE_W:    prdata = 32'(cfg_r.sprite_width);
      REG_MIRROR:      prdata = 32'(cfg_r.mirror);
      REG_FRAME_BASE:  prdata = 32'(cfg_r.frame_base);
      default:         prdata = 32'd0;
    endcase
  end

endmodule

>>> hdl/cpsb_parser.sv
module cpsb_parser (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [cpsb_pkg::BYTE_W-1:0]  data_byte,
  input  logic [cpsb_pkg::COL_W-1:0]   column_index,
  input  logic                         column_start,
  output logic                         pix_valid,
  input  logic                         pix_ready,
  output cpsb_pkg::cpsb_pix_t          pix
);
  import cpsb_pkg::*;

  localparam logic [2:0] PH_DONE  = 3'd0;
  localparam logic [2:0] PH_TOP   = 3'd1;
  localparam logic [2:0] PH_LEN   = 3'd2;
  localparam logic [2:0] PH_PAD_A = 3'd3;
  localparam logic [2:0] PH_PIX   = 3'd4;
  localparam logic [2:0] PH_PAD_B = 3'd5;

  logic [2:0]        phase_r, phase_nxt;
  logic [BYTE_W-1:0] top_r, top_nxt;
  logic [BYTE_W-1:0] len_r, len_nxt;
  logic [BYTE_W-1:0] left_r, left_nxt;
  logic              pix_valid_r;
  cpsb_pix_t         pix_r, pix_nxt;
  logic              in_fire;
  logic              emit;
  logic [BYTE_W-1:0] left_dec;

  assign in_ready  = !pix_valid_r || pix_ready;
  assign in_fire   = in_valid && in_ready;
  assign pix_valid = pix_valid_r;
  assign pix       = pix_r;
  assign left_dec  = left_r - BYTE_W'(1);

  // Post parser: next phase and counters for the word at the input
  always_comb begin
    phase_nxt = phase_r;
    top_nxt   = top_r;
    len_nxt   = len_r;
    left_nxt  = left_r;
    emit      = 1'b0;
    if (column_start || phase_r == PH_TOP) begin
      // top-delta byte, or end of column
      if (data_byte == END_MARK) begin
        phase_nxt = PH_DONE;
      end else begin
        top_nxt   = data_byte;
        phase_nxt = PH_LEN;
      end
    end else begin
      unique case (phase_r)
        PH_LEN: begin
          len_nxt   = data_byte;
          left_nxt  = data_byte;
          phase_nxt = PH_PAD_A;
        end
        PH_PAD_A: phase_nxt = (len_r == '0) ? PH_PAD_B : PH_PIX;
        PH_PAD_B: phase_nxt = PH_TOP;
        PH_PIX: begin
          emit     = 1'b1;
          left_nxt = left_dec;
          if (left_dec == '0) phase_nxt = PH_PAD_B;
        end
        default: phase_nxt = PH_DONE;
      endcase
    end
  end

  // Pixel word for the address stage
  always_comb begin
    pix_nxt.column   = column_index;
    pix_nxt.rowsum   = ROWSUM_W'(top_r) + ROWSUM_W'(len_r - left_r);
    pix_nxt.pixel    = data_byte;
    pix_nxt.post_end = (left_dec == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_DONE;
      top_r       <= '0;
      len_r       <= '0;
      left_r      <= '0;
      pix_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r <= phase_nxt;
        top_r   <= top_nxt;
        len_r   <= len_nxt;
        left_r  <= left_nxt;
      end
      if (in_fire && emit) pix_valid_r <= 1'b1;
      else if (pix_ready)  pix_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) pix_r <= pix_nxt;
  end

  // A pixel word only appears after an accepted word
  a_pix_from_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(pix_valid_r) |-> $past(in_fire))
    else $error("pixel word without accepted input");

  // A pixel byte always yields a pixel word
  a_pix_emitted: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !column_start && phase_r == PH_PIX |=> pix_valid_r)
    else $error("pixel byte dropped");

  // The closing pad always follows the last pixel of a post
  a_post_closes: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && emit && pix_nxt.post_end |=> phase_r == PH_PAD_B)
    else $error("post did not close");

endmodule

>>> hdl/cpsb_addr_gen.sv
module cpsb_addr_gen (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cpsb_pkg::cpsb_cfg_t          cfg,
  input  logic                         pix_valid,
  output logic                         pix_ready,
  input  cpsb_pkg::cpsb_pix_t          pix,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [cpsb_pkg::ADDR_W-1:0]  out_address,
  output logic [cpsb_pkg::BYTE_W-1:0]  out_pixel,
  output logic                         out_clipped,
  output logic                         out_post_end
);
  import cpsb_pkg::*;

  logic signed [DCOL_W-1:0]  sw_s, col_s, dcol;
  logic signed [COORD_W-1:0] sx, sy;
  logic                      clip;
  logic [ADDR_W-1:0]         addr;
  logic                      take;

  logic              out_valid_r;
  logic [ADDR_W-1:0] addr_r;
  logic [BYTE_W-1:0] pixel_r;
  logic              clip_r;
  logic              post_end_r;

  assign pix_ready = !out_valid_r || out_ready;
  assign take      = pix_valid && pix_ready;

  // Destination column, mirrored if asked
  assign sw_s  = $signed({2'b00, cfg.sprite_width});
  assign col_s = $signed({3'b000, pix.column});
  assign dcol  = cfg.mirror ? (sw_s - DCOL_W'(1) - col_s) : col_s;

  // Screen position and clip test
  assign sx = COORD_W'(cfg.origin_x) - COORD_W'(cfg.left_offset) + COORD_W'(dcol);
  assign sy = COORD_W'(cfg.origin_y) - COORD_W'(cfg.top_offset)
            + COORD_W'($signed({1'b0, pix.rowsum}));
  assign clip = (sx < 0) || (sx >= COORD_W'(SCREEN_WIDTH))
             || (sy < 0) || (sy >= COORD_W'(SCREEN_HEIGHT));

  // Linear address; row times width is a constant multiply
  always_comb begin
    if (clip) begin
      addr = '0;
    end else begin
      addr = ADDR_W'(cfg.frame_base)
           + ADDR_W'(sy[Y_BITS-1:0]) * ADDR_W'(SCREEN_WIDTH)
           + ADDR_W'(sx[X_BITS-1:0]);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      addr_r     <= addr;
      pixel_r    <= pix.pixel;
      clip_r     <= clip;
      post_end_r <= pix.post_end;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_address  = addr_r;
  assign out_pixel    = pixel_r;
  assign out_clipped  = clip_r;
  assign out_post_end = post_end_r;

  // A clipped pixel never carries an address
  a_clip_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && clip_r |-> addr_r == '0)
    else $error("clipped pixel with nonzero address");

  // Every pixel word taken shows up as a result next cycle
  a_take_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> out_valid_r)
    else $error("pixel word lost in address stage");

endmodule

>>> hdl/column_post_sprite_blitter_core.sv
// Column-post sprite blitter. Feed the post bytes of each sprite column one
// word per cycle on in_*, with tuser high on the first byte of a column;
// every pixel byte gives one result word carrying its framebuffer address
// (frame_base + row * 320 + column) and the pixel, with tuser marking a
// pixel off the 320x200 screen (address 0, do not write) and tlast marking
// the last pixel of a post. Throughput is one word per cycle while out_tready
// stays high; a pixel byte passes the parser register, then the address
// register, on its way out, and header, pad and end bytes give no result.
// Program the origin, offsets, width, mirror and base through cfg_* while
// the stream is idle; registers lie at byte address 4 * index.
module column_post_sprite_blitter_core (
  input  logic                          clk,
  input  logic                          rst_n,
  // input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [23:0]                   in_tdata,   // [7:0] data_byte, [19:8] column_index
  input  logic                          in_tuser,   // [0] column_start
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [39:0]                   out_tdata,  // [24:0] address, [32:25] pixel
  output logic                          out_tuser,  // [0] clipped
  output logic                          out_tlast,  // post_end
  // configuration
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [cpsb_pkg::PADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);
  import cpsb_pkg::*;

  cpsb_cfg_t         cfg;
  cpsb_pix_t         pix;
  logic              pix_valid;
  logic              pix_ready;
  logic [ADDR_W-1:0] out_address;
  logic [BYTE_W-1:0] out_pixel;

  cpsb_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  cpsb_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .data_byte    (in_tdata[BYTE_W-1:0]),
    .column_index (in_tdata[BYTE_W+COL_W-1:BYTE_W]),
    .column_start (in_tuser),
    .pix_valid    (pix_valid),
    .pix_ready    (pix_ready),
    .pix          (pix)
  );

  cpsb_addr_gen u_addr (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .pix_valid    (pix_valid),
    .pix_ready    (pix_ready),
    .pix          (pix),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_address  (out_address),
    .out_pixel    (out_pixel),
    .out_clipped  (out_tuser),
    .out_post_end (out_tlast)
  );

  // Pack result word, zero fill to whole bytes
  assign out_tdata = {7'd0, out_pixel, out_address};

endmodule

>>> tb/tb_top.sv
module tb_top;
  import cpsb_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int HOLD_CYCLES    = 80;
  localparam int PHASE_BYTES    = 175;
  // write to an index past the register list, must be ignored
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef enum logic [2:0] {
    PH_DONE, PH_TOP, PH_LEN, PH_PAD_A, PH_PIX, PH_PAD_B
  } post_phase_t;

  // one word on the result stream
  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [BYTE_W-1:0] pixel;
    logic              clipped;
    logic              post_end;
  } pix_word_t;

  // one word on the input stream
  typedef struct packed {
    logic [BYTE_W-1:0] b;
    logic [COL_W-1:0]  c;
    logic              s;
  } post_byte_t;

  // Post parser and address predictor, with the queue of pixels still owed
  class blit_scoreboard;
    logic signed [ORG_W-1:0] origin_x, origin_y, left_off, top_off;
    logic [SPW_W-1:0]  sprite_w;
    logic              mirror;
    logic [BASE_W-1:0] frame_base;
    post_phase_t       phase;
    logic [7:0]        top_row, post_len, pix_left;
    pix_word_t         owed_pixels[$];
    int                errors;
    int                parsed;

    function new();
      origin_x = '0;
      origin_y = '0;
      left_off = '0;
      top_off = '0;
      sprite_w = 13'd1;
      mirror = 1'b0;
      frame_base = '0;
      phase = PH_DONE;
      top_row = '0;
      post_len = '0;
      pix_left = '0;
      errors = 0;
      parsed = 0;
    endfunction

    function void set_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] v);
      case (idx)
        REG_ORIGIN_X:    origin_x = v[15:0];
        REG_ORIGIN_Y:    origin_y = v[15:0];
        REG_LEFT_OFFSET: left_off = v[15:0];
        REG_TOP_OFFSET:  top_off = v[15:0];
        REG_SPRITE_W:    sprite_w = v[SPW_W-1:0];
        REG_MIRROR:      mirror = v[0];
        REG_FRAME_BASE:  frame_base = v[BASE_W-1:0];
        default: ;
      endcase
    endfunction

    // top-delta byte: end mark closes the column, else opens a post
    function void open_post(logic [7:0] b);
      if (b == END_MARK) begin
        phase = PH_DONE;
      end else begin
        top_row = b;
        phase = PH_LEN;
      end
    endfunction

    function void take_byte(logic [7:0] b, logic [11:0] c, logic s);
      int row, dcol, sx, sy;
      pix_word_t w;
      if (s || phase != PH_DONE) parsed++;
      if (s) begin
        open_post(b);
        return;
      end
      case (phase)
        PH_TOP: open_post(b);
        PH_LEN: begin
          post_len = b;
          pix_left = b;
          phase = PH_PAD_A;
        end
        PH_PAD_A: phase = (post_len == 0) ? PH_PAD_B : PH_PIX;
        PH_PAD_B: phase = PH_TOP;
        PH_PIX: begin
          row = int'(post_len) - int'(pix_left);
          dcol = mirror ? int'(sprite_w) - 1 - int'(c) : int'(c);
          sx = int'(origin_x) - int'(left_off) + dcol;
          sy = int'(origin_y) - int'(top_off) + int'(top_row) + row;
          w.clipped = (sx < 0) || (sx >= SCREEN_WIDTH) || (sy < 0) || (sy >= SCREEN_HEIGHT);
          w.address = w.clipped ? '0
                                : ADDR_W'(int'(frame_base) + sy * SCREEN_WIDTH + sx);
          pix_left = pix_left - 8'd1;
          w.pixel = b;
          w.post_end = (pix_left == 0);
          if (pix_left == 0) phase = PH_PAD_B;
          owed_pixels.push_back(w);
        end
        default: phase = PH_DONE;
      endcase
    endfunction

    function void check_word(pix_word_t got);
      pix_word_t exp_w;
      if (owed_pixels.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, got addr=%h pix=%h clip=%b last=%b",
                 $time, got.address, got.pixel, got.clipped, got.post_end);
        return;
      end
      exp_w = owed_pixels.pop_front();
      if (got !== exp_w) begin
        errors++;
        $display("%0t: expected addr=%h pix=%h clip=%b last=%b,",
                 $time, exp_w.address, exp_w.pixel, exp_w.clipped, exp_w.post_end,
                 " got addr=%h pix=%h clip=%b last=%b",
                 got.address, got.pixel, got.clipped, got.post_end);
      end
    endfunction

    function int pending();
      return owed_pixels.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // [7:0] data_byte, [19:8] column_index
  logic        in_tuser;   // [0] column_start
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // [24:0] address, [32:25] pixel
  logic        out_tuser;  // [0] clipped
  logic        out_tlast;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [PADDR_W-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  blit_scoreboard sb = new();
  post_byte_t     col_bytes[$];
  int             tx_idle_pct;
  int             rx_idle_pct;
  int             rx_hold;
  int             quiet;

  column_post_sprite_blitter_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Monitor: note accepted bytes, check accepted pixel words
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.take_byte(in_tdata[7:0], in_tdata[19:8], in_tuser);
      if (out_tvalid && out_tready)
        sb.check_word('{out_tdata[24:0], out_tdata[32:25], out_tuser, out_tlast});
    end
  end

  // Watchdog on cycles with no traffic at all
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel || !rst_n)
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: random backpressure, or a long hold when asked
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_tready <= 1'b0;
        rx_hold = rx_hold - 1;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Entered and left at a falling edge; valid stays high after the word
  task automatic send_byte(logic [7:0] b, logic [11:0] c, logic s);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0, c, b};
    in_tuser <= s;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic send_column(int count);
    for (int i = 0; i < count && i < col_bytes.size(); i++)
      send_byte(col_bytes[i].b, col_bytes[i].c, col_bytes[i].s);
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_reg(idx, value);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(int ox, int oy, int lo, int to, int w, int m, int base);
    write_reg(REG_ORIGIN_X, 32'(ox));
    write_reg(REG_ORIGIN_Y, 32'(oy));
    write_reg(REG_LEFT_OFFSET, 32'(lo));
    write_reg(REG_TOP_OFFSET, 32'(to));
    write_reg(REG_SPRITE_W, 32'(w));
    write_reg(REG_MIRROR, 32'(m));
    write_reg(REG_FRAME_BASE, 32'(base));
  endtask

  // Stop sending, let every owed pixel arrive, then let the pipe settle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Source column that usually lands near the screen under the current settings
  function automatic logic [11:0] pick_column();
    int tx, dcol, c;
    if ($urandom_range(9) == 0) return 12'($urandom_range(4095));
    tx = int'($urandom_range(340)) - 10;
    dcol = tx - (int'(sb.origin_x) - int'(sb.left_off));
    c = sb.mirror ? int'(sb.sprite_w) - 1 - dcol : dcol;
    if (c < 0 || c > 4095) c = $urandom_range(4095);
    return 12'(c);
  endfunction

  // Well-formed column: posts of top, length, pad, pixels, pad; then end mark
  function automatic void build_column();
    int n_posts, len, p;
    logic [11:0] c;
    col_bytes.delete();
    c = pick_column();
    n_posts = $urandom_range(3);
    for (p = 0; p < n_posts; p++) begin
      len = ($urandom_range(19) == 0) ? $urandom_range(255) : $urandom_range(6);
      col_bytes.push_back('{8'($urandom_range(254)), c, (p == 0)});
      col_bytes.push_back('{8'(len), c, 1'b0});
      col_bytes.push_back('{8'($urandom), c, 1'b0});
      repeat (len) col_bytes.push_back('{8'($urandom), c, 1'b0});
      col_bytes.push_back('{8'($urandom), c, 1'b0});
    end
    col_bytes.push_back('{END_MARK, c, (n_posts == 0)});
  endfunction

  task automatic random_traffic(int target);
    int kind, n;
    sb.parsed = 0;
    while (sb.parsed < target) begin
      kind = $urandom_range(99);
      if (kind < 80) begin
        build_column();
        send_column(col_bytes.size());
      end else if (kind < 90) begin
        // column cut short; the next start byte abandons it
        build_column();
        send_column($urandom_range(1, col_bytes.size()));
      end else begin
        n = $urandom_range(1, 5);
        repeat (n) send_byte(8'($urandom), 12'($urandom), ($urandom_range(3) == 0));
      end
    end
  endtask

  initial begin
    int ph;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= 1'b0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    rx_hold = 0;
    tx_idle_pct = 26;
    rx_idle_pct = 65;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: stray byte, a three pixel post, an empty post
    send_byte(8'h10, 12'd0, 1'b0);
    send_byte(8'h00, 12'd0, 1'b1);
    send_byte(8'd3, 12'd0, 1'b0);
    send_byte(8'h00, 12'd0, 1'b0);
    send_byte(8'h00, 12'd0, 1'b0);
    send_byte(8'hff, 12'd0, 1'b0);
    send_byte(8'h5a, 12'd0, 1'b0);
    send_byte(8'h00, 12'd0, 1'b0);
    send_byte(8'hfe, 12'd0, 1'b0);
    send_byte(8'd0, 12'd0, 1'b0);
    send_byte(8'h00, 12'd0, 1'b0);
    send_byte(8'h00, 12'd0, 1'b0);
    send_byte(END_MARK, 12'd0, 1'b0);
    wait_idle();

    // Extreme settings, zero width mirrored, restart in the middle of a post
    configure(-32768, 32767, -32768, 32767, 0, 1, 24'hffffff);
    write_reg(REG_UNUSED, 32'hffffffff);
    send_byte(8'd5, 12'hfff, 1'b1);
    send_byte(8'd2, 12'hfff, 1'b0);
    send_byte(8'h00, 12'hfff, 1'b0);
    send_byte(8'ha5, 12'hfff, 1'b0);
    send_byte(8'h00, 12'd0, 1'b1);
    send_byte(8'd1, 12'd0, 1'b0);
    send_byte(8'h00, 12'd0, 1'b0);
    send_byte(8'h3c, 12'd0, 1'b0);
    send_byte(8'h00, 12'd0, 1'b0);
    send_byte(END_MARK, 12'd0, 1'b0);
    wait_idle();

    // Random phases, each with its own settings and idling
    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: configure($urandom_range(200), $urandom_range(120), $urandom_range(30),
                     $urandom_range(30), $urandom_range(1, 64), 0, $urandom_range(24'hffffff));
        1: configure($urandom_range(200), $urandom_range(120), $urandom_range(30),
                     $urandom_range(30), $urandom_range(1, 64), 1, $urandom_range(24'hffffff));
        2: configure(32767, -32768, 32767, -32768, 4096, 1, 0);
        3: configure($urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
                     $urandom_range(65535), $urandom_range(8191), $urandom_range(1),
                     $urandom_range(24'hffffff));
        4: configure($urandom_range(200), $urandom_range(120), $urandom_range(30),
                     $urandom_range(30), $urandom_range(1, 64), $urandom_range(1), 24'hffffff);
        default: configure(-5000, 10, -400, -20, 8191, 1, $urandom_range(24'hffffff));
      endcase
      tx_idle_pct = (ph < 2) ? 26 : (ph < 4) ? 65 : 0;
      rx_idle_pct = (ph < 2) ? 65 : (ph < 4) ? 26 : 0;
      if (ph == 0 || ph == 4) rx_hold = HOLD_CYCLES;
      random_traffic(PHASE_BYTES);
      wait_idle();
    end

    if (sb.errors == 0 && sb.pending() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
